FILE: design/life_like_automaton_row_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life-like automaton row step unit
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_ROW_STEP_UNIT_MACROS_SVH
`define LIFE_LIKE_AUTOMATON_ROW_STEP_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define LLRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define LLRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/llrs_pkg.sv
// ----------------------------------------------------------------------------
// llrs_pkg
// Shared types and constants for the life-like automaton row step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llrs_pkg;

    localparam int ROW_W             = 32;  // bits in one row word
    localparam int LIMIT_W           = 4;   // width of each limit register
    localparam int NCNT_W            = 4;   // neighbor count 0..8
    localparam int CFG_IDX_W         = 1;   // register index width
    localparam int GRID_COLS_DEFAULT = 32;
    localparam int OUT_DEPTH         = 4;   // output queue entries
    localparam int OUT_PTR_W         = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W         = $clog2(OUT_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LONELY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROWD_LIMIT  = 1'd1;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] lonely;
        logic [LIMIT_W-1:0] crowd;
    } limits_t;

    typedef struct packed {
        row_t bits;
        logic last;
    } result_t;

endpackage

FILE: design/llrs_lane.sv
// ----------------------------------------------------------------------------
// llrs_lane
// One column: counts the eight neighbors and applies the survival window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llrs_lane
(
    input  logic [2:0]       above,   // columns k-1, k, k+1 of the row above
    input  logic [1:0]       side,    // columns k-1, k+1 of the centre row
    input  logic [2:0]       below,   // columns k-1, k, k+1 of the row below
    input  llrs_pkg::limits_t limits,
    output logic             live
);
    import llrs_pkg::*;

    logic [NCNT_W-1:0] ncount;

    assign ncount = NCNT_W'(above[0]) + NCNT_W'(above[1]) + NCNT_W'(above[2])
                  + NCNT_W'(side[0])  + NCNT_W'(side[1])
                  + NCNT_W'(below[0]) + NCNT_W'(below[1]) + NCNT_W'(below[2]);

    assign live = (ncount > limits.lonely) && (ncount < limits.crowd);

endmodule

FILE: design/llrs_row_engine.sv
// ----------------------------------------------------------------------------
// llrs_row_engine
// Lane array for one row: one lane per grid column, lane bits merged into
// the next-generation row word. Columns beyond the grid stay zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llrs_row_engine
#(
    parameter int GRID_COLS = llrs_pkg::GRID_COLS_DEFAULT
)
(
    input  llrs_pkg::row_t    above,
    input  llrs_pkg::row_t    mid,
    input  llrs_pkg::row_t    below,
    input  llrs_pkg::limits_t limits,
    output llrs_pkg::row_t    next_row
);
    import llrs_pkg::*;

    localparam int LANES = (GRID_COLS < ROW_W) ? GRID_COLS : ROW_W;

    // dead border column on each side
    logic [ROW_W+1:0] above_pad;
    logic [ROW_W+1:0] mid_pad;
    logic [ROW_W+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign mid_pad   = {1'b0, mid,   1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    for (genvar k = 0; k < ROW_W; k++)
    begin : g_col
        if (k < LANES)
        begin : g_lane
            llrs_lane u_lane
            (
                .above  (above_pad[k+2:k]),
                .side   ({mid_pad[k+2], mid_pad[k]}),
                .below  (below_pad[k+2:k]),
                .limits (limits),
                .live   (next_row[k])
            );
        end
        else
        begin : g_off
            assign next_row[k] = 1'b0;
        end
    end

endmodule

FILE: design/life_like_automaton_row_step_unit.sv
// ----------------------------------------------------------------------------
// life_like_automaton_row_step_unit
// One generation step of a life-like cellular automaton, streamed by rows.
// ----------------------------------------------------------------------------
// Rows of the present generation enter top to bottom, one 32-bit word per
// transfer, tlast on the frame's last row. A cell is live in the next
// generation when lonely_limit < (live Moore neighbors) < crowd_limit, its
// own state does not matter, and everything outside the grid is dead. The
// next row for a centre row leaves once the row below it has arrived: in a
// frame of several rows the first yields nothing and the final row yields
// two (the row before it and itself, the latter with tlast); a one-row frame
// yields one, with tlast. The unit takes one row per clock while the slave
// side is ready: two lane arrays of GRID_COLS lanes (32 at most) work in the
// transfer cycle and write up to two results into a four-entry registered
// output queue. The slave side is ready while two queue entries are free,
// so sustained rate is one row per clock whenever the master side takes one
// result per clock. Limits must be written only between frames (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_like_automaton_row_step_unit
#(
    parameter int GRID_COLS = llrs_pkg::GRID_COLS_DEFAULT   // 3..64
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    // configuration write port
    input  logic                             cfg_we,
    input  logic [llrs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [llrs_pkg::LIMIT_W-1:0]     cfg_wdata,

    // present-generation rows
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [llrs_pkg::ROW_W-1:0]       s_axis_tdata,   // [31:0] row_bits
    input  logic                             s_axis_tlast,   // final_row

    // next-generation rows
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [llrs_pkg::ROW_W-1:0]       m_axis_tdata,   // [31:0] next_row_bits
    output logic                             m_axis_tlast    // last_out
);
    import llrs_pkg::*;

    localparam int   LANES    = (GRID_COLS < ROW_W) ? GRID_COLS : ROW_W;
    localparam row_t COL_MASK = ROW_W'((64'd1 << LANES) - 64'd1);

    // ------------------------------------------------------------------
    // Limit registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] lonely_reg;
    logic [LIMIT_W-1:0] crowd_reg;
    limits_t            limits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lonely_reg <= LIMIT_W'(0);
            crowd_reg  <= LIMIT_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LONELY_LIMIT: lonely_reg <= cfg_wdata;
                REG_CROWD_LIMIT:  crowd_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign limits.lonely = lonely_reg;
    assign limits.crowd  = crowd_reg;

    // ------------------------------------------------------------------
    // Row window: upper and centre rows, plus a flag that a centre row
    // is waiting for the row below it.
    // ------------------------------------------------------------------
    row_t upper_reg, upper_next;
    row_t centre_reg, centre_next;
    logic held_reg, held_next;

    logic in_xfer;
    row_t row_in;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign row_in  = s_axis_tdata & COL_MASK;   // columns past the grid are dead

    // Lane array A: successor of the held centre row (row below = new row).
    // Lane array B: successor of the new row when it closes the frame.
    row_t gen_mid;
    row_t gen_final;
    row_t final_above;

    assign final_above = held_reg ? centre_reg : '0;

    llrs_row_engine #(.GRID_COLS(GRID_COLS)) u_engine_mid
    (
        .above    (upper_reg),
        .mid      (centre_reg),
        .below    (row_in),
        .limits   (limits),
        .next_row (gen_mid)
    );

    llrs_row_engine #(.GRID_COLS(GRID_COLS)) u_engine_final
    (
        .above    (final_above),
        .mid      (row_in),
        .below    ('0),
        .limits   (limits),
        .next_row (gen_final)
    );

    always_comb
    begin
        upper_next  = upper_reg;
        centre_next = centre_reg;
        held_next   = held_reg;
        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                // end of frame: next transfer starts a fresh grid
                upper_next  = '0;
                centre_next = '0;
                held_next   = 1'b0;
            end
            else
            begin
                upper_next  = held_reg ? centre_reg : '0;
                centre_next = row_in;
                held_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= '0;
            centre_reg <= '0;
            held_reg   <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            centre_reg <= centre_next;
            held_reg   <= held_next;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: up to two writes and one read per cycle.
    // ------------------------------------------------------------------
    result_t                 out_q [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]    fill_reg, fill_next;

    logic                    wr_first;   // at least one result this transfer
    logic                    wr_second;  // middle row and final row both out
    logic [1:0]              n_push;
    logic                    pop;
    result_t                 slot0;
    result_t                 slot1;

    assign wr_first  = in_xfer && (held_reg || s_axis_tlast);
    assign wr_second = in_xfer && held_reg && s_axis_tlast;
    assign n_push    = {1'b0, wr_first} + {1'b0, wr_second};
    assign pop       = m_axis_tvalid && m_axis_tready;

    assign slot0.bits = held_reg ? gen_mid : gen_final;
    assign slot0.last = !held_reg;
    assign slot1.bits = gen_final;
    assign slot1.last = 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            out_q[wr_ptr_reg] <= slot0;
        end
        if (wr_second)
        begin
            out_q[wr_ptr_reg + OUT_PTR_W'(1)] <= slot1;
        end
    end

    assign wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
    assign fill_next   = fill_reg + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // ready while a final row's two results still fit
    assign s_axis_tready = (fill_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    assign m_axis_tvalid = (fill_reg != '0);
    assign m_axis_tdata  = out_q[rd_ptr_reg].bits;
    assign m_axis_tlast  = out_q[rd_ptr_reg].last;

endmodule

FILE: design/llrs_checker.sv
// ----------------------------------------------------------------------------
// llrs_checker
// Port-level checks for the life-like automaton row step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "life_like_automaton_row_step_unit_macros.svh"

module llrs_checker
#(
    parameter int GRID_COLS = llrs_pkg::GRID_COLS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             s_axis_tlast,   // final_row
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [llrs_pkg::ROW_W-1:0]       m_axis_tdata,   // [31:0] next_row_bits
    input  logic                             m_axis_tlast    // last_out
);
    import llrs_pkg::*;

    localparam int   LANES    = (GRID_COLS < ROW_W) ? GRID_COLS : ROW_W;
    localparam row_t COL_MASK = ROW_W'((64'd1 << LANES) - 64'd1);

    // a stalled result holds
    `LLRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result changed while stalled")

    // a final row always leaves at least one result behind it
    `LLRS_ASSERT_NEXT(a_final_emits, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        m_axis_tvalid, "final row transfer produced no result")

    // backpressure only while results are queued
    `LLRS_ASSERT_NOW(a_stall_has_data, !s_axis_tready, m_axis_tvalid,
        "input stalled with empty output queue")

    // columns past the grid are never live
    `LLRS_ASSERT_NOW(a_out_cols, m_axis_tvalid, (m_axis_tdata & ~COL_MASK) == '0,
        "live cell reported outside the grid")

endmodule

bind life_like_automaton_row_step_unit llrs_checker #(.GRID_COLS(GRID_COLS)) u_llrs_checker (.*);

FILE: bench/llrs_generation_checker.sv
// ----------------------------------------------------------------------------
// llrs_generation_checker
// Watches the row streams and checks every next-generation row.
// ----------------------------------------------------------------------------
// Tracks limit writes and accepted rows, computes the next-generation rows
// they cause, and compares each master-side transfer with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llrs_generation_checker
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [llrs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [llrs_pkg::LIMIT_W-1:0]     cfg_wdata,

    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [llrs_pkg::ROW_W-1:0]       s_axis_tdata,   // [31:0] row_bits
    input  logic                             s_axis_tlast,   // final_row

    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [llrs_pkg::ROW_W-1:0]       m_axis_tdata,   // [31:0] next_row_bits
    input  logic                             m_axis_tlast,   // last_out

    output int                               mismatch_count,
    output int                               rows_outstanding
);

    import llrs_pkg::*;

    logic [LIMIT_W-1:0] lonely_lim = 4'd0;
    logic [LIMIT_W-1:0] crowd_lim  = 4'd3;
    row_t               mid_row    = '0;
    row_t               top_row    = '0;
    logic [1:0]         held_rows  = 2'd0;

    result_t            next_rows_q[$];

    // out-of-grid cells are dead
    function automatic int live_at(row_t r, int col);
        if (col < 0 || col >= ROW_W)
            return 0;
        return int'(r[col]);
    endfunction

    function automatic row_t successor(row_t above, row_t mid, row_t below,
                                       logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] hi);
        row_t res;
        int   n;
        res = '0;
        for (int k = 0; k < ROW_W; k++)
        begin
            n = live_at(above, k - 1) + live_at(above, k) + live_at(above, k + 1)
              + live_at(mid, k - 1)   + live_at(mid, k + 1)
              + live_at(below, k - 1) + live_at(below, k) + live_at(below, k + 1);
            if (n > int'(lo) && n < int'(hi))
                res[k] = 1'b1;
        end
        return res;
    endfunction

    task automatic take_row(row_t r, logic is_last);
        result_t e;
        if (held_rows != 2'd0)
        begin
            e.bits = successor(top_row, mid_row, r, lonely_lim, crowd_lim);
            e.last = 1'b0;
            next_rows_q.push_back(e);
            top_row   = mid_row;
            held_rows = 2'd2;
        end
        else
        begin
            top_row   = '0;
            held_rows = 2'd1;
        end
        mid_row = r;
        if (is_last)
        begin
            e.bits = successor(top_row, mid_row, '0, lonely_lim, crowd_lim);
            e.last = 1'b1;
            next_rows_q.push_back(e);
            mid_row   = '0;
            top_row   = '0;
            held_rows = 2'd0;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.bits = m_axis_tdata;
                got.last = m_axis_tlast;
                if (next_rows_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected row %h last %b", $realtime,
                                 got.bits, got.last);
                end
                else
                begin
                    want = next_rows_q.pop_front();
                    if (got.bits !== want.bits || got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: row expected %h last %b, got %h last %b",
                                     $realtime, want.bits, want.last, got.bits, got.last);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_LONELY_LIMIT)
                    lonely_lim = cfg_wdata;
                else if (cfg_addr == REG_CROWD_LIMIT)
                    crowd_lim = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                take_row(s_axis_tdata, s_axis_tlast);
        end
        rows_outstanding = next_rows_q.size();
    end

endmodule

FILE: bench/tb_life_like_automaton_row_step_unit.sv
// ----------------------------------------------------------------------------
// tb_life_like_automaton_row_step_unit
// Stimulus and verdict for the life-like automaton row step unit.
// ----------------------------------------------------------------------------
// Streams grid frames through the unit under a range of neighbor limits and
// handshake idling patterns; the checker beside the unit computes every
// next-generation row and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_life_like_automaton_row_step_unit;

    import llrs_pkg::*;

    // handshake idling patterns, one per phase in turn
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    localparam int HOLD_CYCLES = 80;    // long master-side hold-off
    localparam int PHASE_ROWS  = 115;   // minimum rows per random phase
    localparam int NUM_PHASES  = 12;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = REG_LONELY_LIMIT;
    logic [LIMIT_W-1:0]   cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    row_t                 s_axis_tdata  = '0;   // [31:0] row_bits
    logic                 s_axis_tlast  = 1'b0; // final_row
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    row_t                 m_axis_tdata;         // [31:0] next_row_bits
    logic                 m_axis_tlast;         // last_out

    int                   mismatch_count;
    int                   rows_outstanding;

    // percent chance per cycle of an idle sender / stalling receiver
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;

    // limit settings for the random phases; extremes included
    logic [LIMIT_W-1:0]   lonely_set [NUM_PHASES] = '{4'd0, 4'd1, 4'd8, 4'd2, 4'd0, 4'd15,
                                                      4'd7, 4'd0, 4'd3, 4'd1, 4'd0, 4'd4};
    logic [LIMIT_W-1:0]   crowd_set  [NUM_PHASES] = '{4'd3, 4'd4, 4'd15, 4'd4, 4'd0, 4'd15,
                                                      4'd9, 4'd9, 4'd9, 4'd2, 4'd1, 4'd8};

    always #5 clk = ~clk;

    life_like_automaton_row_step_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    llrs_generation_checker u_gen_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast),
        .mismatch_count   (mismatch_count),
        .rows_outstanding (rows_outstanding)
    );

    // Receiver: random stalls, plus a long counted hold-off on request.
    // The hold-off fills the four-entry output queue so tready drops upstream.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Row patterns: empty, full, sparse, dense, lone cells, edge columns.
    // Sparse and lone-cell rows keep neighbor counts in the low range.
    function automatic row_t random_row();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom & $urandom & $urandom;
            4:       return $urandom | $urandom;
            5:       return row_t'(1) << $urandom_range(ROW_W - 1);
            6:       return 32'h8000_0001 | ($urandom & $urandom);
            default: return $urandom;
        endcase
    endfunction

    // One row transfer; called and returning just after a falling edge.
    // tvalid stays high into the next call unless that call idles first.
    task automatic send_row(input row_t r, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Sender pauses until every expected row has come back. A first row of a
    // frame yields nothing at once, so spare idle cycles follow.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (rows_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Both limits, back to back on the write port; only between frames.
    task automatic set_limits(input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LONELY_LIMIT;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_addr  <= REG_CROWD_LIMIT;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 68; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endtask

    // A frame of random rows; now and then the sender waits mid-frame
    // for the outstanding rows, with rows still held inside the unit.
    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_row(random_row(), i == len - 1);
            if (i != len - 1 && $urandom_range(15) == 0)
                wait_drain();
        end
    endtask

    initial
    begin
        int phase_rows;
        int len;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset limits first (live on one or two neighbors).
        // Single-row frames: nothing held, one result carrying tlast.
        send_row(32'hFFFF_FFFF, 1'b1);
        send_row(32'h0000_0001, 1'b1);
        // Multi-row frame: first row silent, edge columns, final row yields two.
        send_row(32'h8000_0001, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h5555_5555, 1'b0);
        send_row(32'hAAAA_AAAA, 1'b1);
        wait_drain();
        set_limits(4'd1, 4'd4);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0007, 1'b0);
        send_row(32'h8000_0000, 1'b1);
        wait_drain();
        // Out-of-range limits: every cell dead.
        set_limits(4'd15, 4'd15);
        send_row(32'hDEAD_BEEF, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1);
        wait_drain();
        set_limits(4'd0, 4'd9);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0001_0000, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1);
        wait_drain();
        // Only fully surrounded cells live.
        set_limits(4'd7, 4'd9);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1);

        // Random phases; limits change only once the unit is drained.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drain();
            set_limits(lonely_set[p], crowd_set[p]);
            set_idling(idle_mode_e'(p % 4));
            // first phase: receiver holds off while rows keep coming
            if (p == 0)
                hold_req = 1'b1;
            phase_rows = 0;
            while (phase_rows < PHASE_ROWS)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_frame(len);
                phase_rows += len;
            end
        end

        // drain, then a tail to catch stray transfers
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit: far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
